// ===== hw/rtl/tbphd_pkg.sv =====
`default_nettype none

package tbphd_pkg;

    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 1;
    localparam int TIME_W    = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD     = 1'd1;

    localparam logic [CFG_W-1:0] DEBOUNCE_RESET = 16'd50;
    localparam logic [CFG_W-1:0] HOLD_RESET     = 16'd800;

    localparam logic [1:0] BTN_FIRST  = 2'd0;
    localparam logic [1:0] BTN_SECOND = 2'd1;
    localparam logic [1:0] BTN_BOTH   = 2'd2;

    localparam logic [1:0] EV_PRESS     = 2'd0;
    localparam logic [1:0] EV_HOLD      = 2'd1;
    localparam logic [1:0] EV_HOLD_BOTH = 2'd2;

    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int COUNT_W    = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [TIME_W-1:0] now_ms;
        logic              first_level;
        logic              second_level;
    } t_in;

    typedef struct packed {
        logic [1:0] which_button;
        logic [1:0] event_kind;
        logic       last_of_run;
    } t_out;

    typedef struct packed {
        logic [1:0] cnt;
        t_out       res0;
        t_out       res1;
    } t_push;

endpackage

`default_nettype wire

// ===== hw/rtl/tbphd_core.sv =====
`default_nettype none

module tbphd_core (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    input  wire tbphd_pkg::t_in            i_in,
    input  wire logic [tbphd_pkg::CFG_W-1:0] i_debounce,
    input  wire logic [tbphd_pkg::CFG_W-1:0] i_hold,
    output tbphd_pkg::t_push               o_push
);
    import tbphd_pkg::*;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'b0001,
        PH_DEBOUNCE = 4'b0010,
        PH_PRESSED  = 4'b0100,
        PH_WAIT_REL = 4'b1000
    } t_phase;

    t_phase            r_phase [2];
    logic [TIME_W-1:0] r_entry [2];
    t_phase            n_phase [2];
    logic [TIME_W-1:0] n_entry [2];

    t_phase            p_phase [2];
    logic [TIME_W-1:0] p_entry [2];
    logic [1:0]        down;
    logic [1:0]        deb_ok;
    logic [1:0]        hold_ok;
    logic [1:0]        emit;
    logic [1:0]        kind [2];
    logic              both_cand;
    logic              both_held;
    logic              swallow;
    logic [TIME_W-1:0] elapsed [2];

    assign down = {~i_in.second_level, ~i_in.first_level};

    always_comb begin
        for (int b = 0; b < 2; b++) begin
            elapsed[b] = i_in.now_ms - r_entry[b];
            deb_ok[b]  = elapsed[b] >= {{(TIME_W-CFG_W){1'b0}}, i_debounce};
            hold_ok[b] = elapsed[b] >= {{(TIME_W-CFG_W){1'b0}}, i_hold};
            p_phase[b] = r_phase[b];
            p_entry[b] = r_entry[b];
            emit[b]    = 1'b0;
            kind[b]    = EV_PRESS;
            unique case (r_phase[b])
                PH_IDLE: begin
                    if (down[b]) begin
                        p_phase[b] = PH_DEBOUNCE;
                        p_entry[b] = i_in.now_ms;
                    end
                end
                PH_DEBOUNCE: begin
                    if (!down[b]) begin
                        p_phase[b] = PH_IDLE;
                    end else if (deb_ok[b]) begin
                        p_phase[b] = PH_PRESSED;
                        p_entry[b] = i_in.now_ms;
                    end
                end
                PH_PRESSED: begin
                    if (!down[b] || hold_ok[b]) begin
                        emit[b]    = 1'b1;
                        kind[b]    = down[b] ? EV_HOLD : EV_PRESS;
                        p_phase[b] = PH_WAIT_REL;
                        p_entry[b] = i_in.now_ms;
                    end
                end
                PH_WAIT_REL: begin
                    if (down[b]) begin
                        p_entry[b] = i_in.now_ms;
                    end else if (deb_ok[b]) begin
                        p_phase[b] = PH_IDLE;
                    end
                end
                default: begin
                    p_phase[b] = PH_IDLE;
                end
            endcase
        end
    end

    assign both_cand = (r_phase[0] == PH_PRESSED) && (r_phase[1] == PH_PRESSED)
                       && down[0] && down[1];
    assign both_held = both_cand && hold_ok[0] && hold_ok[1];
    assign swallow   = both_cand && (hold_ok[0] ^ hold_ok[1]);

    always_comb begin
        o_push      = '0;
        n_phase[0]  = r_phase[0];
        n_phase[1]  = r_phase[1];
        n_entry[0]  = r_entry[0];
        n_entry[1]  = r_entry[1];
        if (i_valid) begin
            if (both_held) begin
                o_push.cnt  = 2'd1;
                o_push.res0 = '{which_button: BTN_BOTH, event_kind: EV_HOLD_BOTH,
                                last_of_run: 1'b1};
                n_phase[0]  = PH_WAIT_REL;
                n_phase[1]  = PH_WAIT_REL;
                n_entry[0]  = i_in.now_ms;
                n_entry[1]  = i_in.now_ms;
            end else if (!swallow) begin
                n_phase = p_phase;
                n_entry = p_entry;
                if (emit[0]) begin
                    o_push.res0 = '{which_button: BTN_FIRST, event_kind: kind[0],
                                    last_of_run: !emit[1]};
                    o_push.res1 = '{which_button: BTN_SECOND, event_kind: kind[1],
                                    last_of_run: 1'b1};
                    o_push.cnt  = emit[1] ? 2'd2 : 2'd1;
                end else if (emit[1]) begin
                    o_push.res0 = '{which_button: BTN_SECOND, event_kind: kind[1],
                                    last_of_run: 1'b1};
                    o_push.cnt  = 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase[0] <= PH_IDLE;
            r_phase[1] <= PH_IDLE;
            r_entry[0] <= '0;
            r_entry[1] <= '0;
        end else begin
            r_phase <= n_phase;
            r_entry <= n_entry;
        end
    end

    a_both_held_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push.cnt != 2'd0 && o_push.res0.which_button == BTN_BOTH)
            |-> (o_push.cnt == 2'd1))
        else $error("hold of both shares a sample with another event");

    a_both_held_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        both_held && i_valid |=> (r_phase[0] == PH_WAIT_REL) && (r_phase[1] == PH_WAIT_REL))
        else $error("hold of both did not park both buttons");

    a_swallow_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        swallow && i_valid |-> (o_push.cnt == 2'd0))
        else $error("swallowed sample produced an event");

endmodule

`default_nettype wire

// ===== hw/rtl/tbphd_fifo.sv =====
`default_nettype none

module tbphd_fifo (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire tbphd_pkg::t_push  i_push,
    output logic                   o_room2,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output tbphd_pkg::t_out        o_data
);
    import tbphd_pkg::*;

    t_out               r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]   r_wr;
    logic [PTR_W-1:0]   r_rd;
    logic [COUNT_W-1:0] r_count;
    logic [COUNT_W-1:0] n_count;
    logic               pop;

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];
    assign pop     = o_valid && !i_stall;
    assign o_room2 = (r_count <= COUNT_W'(FIFO_DEPTH - 2));
    assign n_count = r_count + COUNT_W'(i_push.cnt) - COUNT_W'(pop);

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wr] <= i_push.res0;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[r_wr + PTR_W'(1)] <= i_push.res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + PTR_W'(i_push.cnt);
            r_rd    <= r_rd + PTR_W'(pop);
            r_count <= n_count;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.cnt != 2'd0) |->
            ({1'b0, r_count} + (COUNT_W + 1)'(i_push.cnt))
                <= (COUNT_W + 1)'(FIFO_DEPTH) + (COUNT_W + 1)'(pop))
        else $error("result queue overflow");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_W'(FIFO_DEPTH))
        else $error("result queue count out of range");

    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop && !o_data.last_of_run |=> o_valid)
        else $error("event run broken in result queue");

endmodule

`default_nettype wire

// ===== hw/rtl/two_button_press_hold_detector.sv =====
`default_nettype none

// Two-button press/hold detector. Each input transaction is one poll sample
// (time in ms plus raw active-low levels of both buttons); it yields zero, one
// or two event transactions in order, the last flagged by last_of_run. A
// sample is registered, then evaluated by the per-button debounce machines;
// its events pass through the result queue. A new sample is taken every
// cycle while the four-entry result queue has room for two more events, so
// the sustained rate is one sample per cycle, bounded by the single event
// per cycle the output delivers while not stalled. Registers: index 0 is the
// debounce time, index 1 the hold time, both in ms; write them only while idle.
module two_button_press_hold_detector (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire tbphd_pkg::t_in                i_in_data,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output tbphd_pkg::t_out                    o_out_data,
    input  wire logic                          i_cfg_we,
    input  wire logic [tbphd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [tbphd_pkg::CFG_W-1:0]   i_cfg_data
);
    import tbphd_pkg::*;

    logic [CFG_W-1:0] r_debounce;
    logic [CFG_W-1:0] r_hold;
    logic             r_in_valid;
    t_in              r_in;
    logic             room2;
    logic             proc;
    t_push            push;

    assign proc       = r_in_valid && room2;
    assign o_in_stall = r_in_valid && !room2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce <= DEBOUNCE_RESET;
            r_hold     <= HOLD_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DEBOUNCE: r_debounce <= i_cfg_data;
                CFG_HOLD:     r_hold     <= i_cfg_data;
                default:      ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_data;
        end
    end

    tbphd_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (proc),
        .i_in       (r_in),
        .i_debounce (r_debounce),
        .i_hold     (r_hold),
        .o_push     (push)
    );

    tbphd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room2 (room2),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (o_out_data)
    );

endmodule

`default_nettype wire
